[src/seven_segment_scan_driver_assert.svh]
// ----------------------------------------------------------------------------
// seven segment scan driver assertion macros
// assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define SSD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SSD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// types, constants and the segment table of the seven segment scan driver
// ----------------------------------------------------------------------------
package ssd_pkg;

  // digits on the display; the scan is clamped to the store depth
  localparam int DIGITS      = 4;
  localparam int STORE_DEPTH = 4;
  localparam int SCAN_COUNT  = (DIGITS < 1) ? 1 :
                               ((DIGITS > STORE_DEPTH) ? STORE_DEPTH : DIGITS);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SEG_W       = 8;
  localparam int WORD_BITS   = 16;
  localparam int COUNT_W     = $clog2(WORD_BITS);
  localparam int VALUE_W     = 14;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 14'd9999;
  localparam logic [SEG_W-1:0]   BLANK     = 8'hFF;
  localparam logic [SEG_W-1:0]   DOT_MASK  = 8'h7F;

  // divide by ten: q = (v * 0xCCCD) >> 19, exact for 14-bit v in 30 bits
  localparam int PROD_W    = 30;
  localparam int DIV_SHIFT = 19;
  localparam logic [15:0] RECIP_10 = 16'hCCCD;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SHOW  = 2'd1,
    CMD_RAW   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SHOW,
    SEQ_CLEAR
  } seq_state_t;

  // active-low pattern of a decimal digit, bit 7 is the point
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
    logic [SEG_W-1:0] p;
    case (digit)
      4'd0: p = 8'hC0;
      4'd1: p = 8'hF9;
      4'd2: p = 8'hA4;
      4'd3: p = 8'hB0;
      4'd4: p = 8'h99;
      4'd5: p = 8'h92;
      4'd6: p = 8'h82;
      4'd7: p = 8'hF8;
      4'd8: p = 8'h80;
      4'd9: p = 8'h90;
      default: p = BLANK;
    endcase
    return p;
  endfunction

endpackage

[src/ssd_ram.sv]
// ----------------------------------------------------------------------------
// ssd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/seven_segment_scan_driver.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// four digit multiplexed seven segment driver feeding two chained shift
// registers
// ----------------------------------------------------------------------------
// The block holds one active-low segment byte per digit in a small ram. Input
// words carry a command in s_tuser: a tick scans the current digit and sends
// 16 output words, one bit each, msb first (segment byte, then the one-hot
// digit select), with m_tlast marking the latch pulse on the sixteenth bit;
// show splits a number (saturated at 9999) into decimal digits, blanks
// leading zeros unless show_zero is set and clears the point of the chosen
// digit if it is shown (dot position zero sets no point); raw set writes one
// byte; clear blanks every digit. A tick passes through the registered ram
// read and then the output shifter, one word per cycle when m_tready stays
// high; a second tick is taken while the first is still shifting and waits
// in a one-word holding register, so ticks run back to back. Show and clear
// make one ram write per digit in turn through the single write port; raw
// set is written in the cycle it is accepted. All of these may be accepted
// while a tick is being shifted out. The store reads as blank after reset
// through per-entry valid flags, so there is no clearing pass.
module seven_segment_scan_driver
  import ssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // value[13:0], show_zero[14], dot_position[16:15], raw_pattern[24:17],
  // position[26:25], zero fill[31:27]
  input  logic [31:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // serial_bit[0], digit_index[2:1], zero fill[7:3]
  output logic [7:0]  m_tdata,
  // latch
  output logic        m_tlast
);

  // input word fields
  cmd_t               cmd;
  logic [VALUE_W-1:0] in_value;
  logic               in_show_zero;
  logic [1:0]         in_dot;
  logic [SEG_W-1:0]   in_raw;
  logic [ADDR_W-1:0]  in_pos;

  assign cmd          = cmd_t'(s_tuser);
  assign in_value     = s_tdata[13:0];
  assign in_show_zero = s_tdata[14];
  assign in_dot       = s_tdata[16:15];
  assign in_raw       = s_tdata[24:17];
  assign in_pos       = s_tdata[26:25];

  logic in_acc;
  logic tick_acc;

  assign in_acc   = s_tvalid && s_tready;
  assign tick_acc = in_acc && (cmd == CMD_TICK);

  // segment store and its reset-valid flags
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [SEG_W-1:0]       ram_wdata;
  logic [SEG_W-1:0]       ram_rdata;
  logic [STORE_DEPTH-1:0] entry_valid;
  logic [ADDR_W-1:0]      scan_digit;

  ssd_ram #(
    .WIDTH (SEG_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_digit),
    .rdata (ram_rdata)
  );

  // write sequencer for show and clear, one digit per cycle
  seq_state_t         seq_state;
  seq_state_t         seq_state_next;
  logic [ADDR_W-1:0]  seq_idx;
  logic [VALUE_W-1:0] seq_val;
  logic               seq_zero;
  logic [1:0]         seq_dot;
  logic               seq_last;

  assign seq_last = (seq_idx == ADDR_W'(STORE_DEPTH - 1));

  // one decimal digit a cycle: remaining value over ten and its remainder
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] rem_full;
  logic               shown;
  logic               dot_hit;
  logic [SEG_W-1:0]   show_pattern;

  always_comb begin
    prod     = PROD_W'(seq_val) * PROD_W'(RECIP_10);
    quot     = VALUE_W'(prod[PROD_W-1:DIV_SHIFT]);
    rem_full = seq_val - (quot << 3) - (quot << 1);
    // digit 0 always shows; the others show with show_zero or a value left
    shown    = (seq_idx == '0) || seq_zero || (seq_val != '0);
    dot_hit  = (seq_dot != 2'd0) && (seq_dot == 2'(seq_idx));
    if (shown) begin
      show_pattern = seg_pattern(rem_full[3:0]) & (dot_hit ? DOT_MASK : BLANK);
    end else begin
      show_pattern = BLANK;
    end
  end

  // next state
  always_comb begin
    seq_state_next = seq_state;
    case (seq_state)
      SEQ_IDLE: begin
        if (in_acc && (cmd == CMD_SHOW)) begin
          seq_state_next = SEQ_SHOW;
        end else if (in_acc && (cmd == CMD_CLEAR)) begin
          seq_state_next = SEQ_CLEAR;
        end
      end
      SEQ_SHOW, SEQ_CLEAR: begin
        if (seq_last) begin
          seq_state_next = SEQ_IDLE;
        end
      end
      default: seq_state_next = SEQ_IDLE;
    endcase
  end

  // ram write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_pos;
    ram_wdata = in_raw;
    case (seq_state)
      SEQ_IDLE: begin
        ram_we = in_acc && (cmd == CMD_RAW);
      end
      SEQ_SHOW: begin
        ram_we    = 1'b1;
        ram_waddr = seq_idx;
        ram_wdata = show_pattern;
      end
      SEQ_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = seq_idx;
        ram_wdata = BLANK;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= SEQ_IDLE;
    end else begin
      seq_state <= seq_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_state == SEQ_IDLE) begin
      seq_idx <= '0;
      if (in_acc && (cmd == CMD_SHOW)) begin
        seq_val  <= (in_value > MAX_VALUE) ? MAX_VALUE : in_value;
        seq_zero <= in_show_zero;
        seq_dot  <= in_dot;
      end
    end else begin
      seq_idx <= seq_idx + 1'b1;
      seq_val <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[ram_waddr] <= 1'b1;
    end
  end

  // scan pointer, moves on with every accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_digit <= '0;
    end else if (tick_acc) begin
      if (scan_digit == ADDR_W'(SCAN_COUNT - 1)) begin
        scan_digit <= '0;
      end else begin
        scan_digit <= scan_digit + 1'b1;
      end
    end
  end

  // read return stage, valid in the cycle after the tick
  logic                 rd_pend;
  logic [ADDR_W-1:0]    rd_digit;
  logic                 rd_valid;
  logic [WORD_BITS-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= tick_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      rd_digit <= scan_digit;
      rd_valid <= entry_valid[scan_digit];
    end
  end

  // segment byte first, then one-hot digit select
  assign rd_word = {(rd_valid ? ram_rdata : BLANK), (8'd1 << rd_digit)};

  // holding word and output shifter
  logic                 hold_valid;
  logic [WORD_BITS-1:0] hold_word;
  logic [ADDR_W-1:0]    hold_digit;
  logic                 sh_active;
  logic [WORD_BITS-1:0] sh_word;
  logic [COUNT_W-1:0]   sh_count;
  logic [ADDR_W-1:0]    sh_digit;
  logic                 sh_last;
  logic                 out_fire;
  logic                 sh_free;

  assign sh_last  = (sh_count == COUNT_W'(WORD_BITS - 1));
  assign out_fire = sh_active && m_tready;
  assign sh_free  = !sh_active || (out_fire && sh_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      sh_active  <= 1'b0;
    end else begin
      if (sh_free) begin
        if (hold_valid) begin
          sh_active  <= 1'b1;
          hold_valid <= 1'b0;
        end else begin
          sh_active <= rd_pend;
        end
      end else if (rd_pend) begin
        hold_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sh_free) begin
      sh_count <= '0;
      if (hold_valid) begin
        sh_word  <= hold_word;
        sh_digit <= hold_digit;
      end else begin
        sh_word  <= rd_word;
        sh_digit <= rd_digit;
      end
    end else if (out_fire) begin
      sh_word  <= sh_word << 1;
      sh_count <= sh_count + 1'b1;
    end
    if (rd_pend && !sh_free) begin
      hold_word  <= rd_word;
      hold_digit <= rd_digit;
    end
  end

  // a new word is taken when the sequencer is idle and the tick path has room
  assign s_tready = (seq_state == SEQ_IDLE) && !hold_valid && !rd_pend;

  assign m_tvalid = sh_active;
  assign m_tdata  = {5'd0, sh_digit, sh_word[WORD_BITS-1]};
  assign m_tlast  = sh_last;

endmodule

[src/ssd_checker.sv]
// ----------------------------------------------------------------------------
// ssd_checker
// port level checks of the seven segment scan driver, bound to the top level
// ----------------------------------------------------------------------------
`include "seven_segment_scan_driver_assert.svh"

module ssd_checker
  import ssd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  // stalled output word holds
  `SSD_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

  // a burst of one scan keeps its digit until the latch word
  `SSD_ASSERT(a_burst_digit, clk, rst, m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tdata[2:1] == $past(m_tdata[2:1])), "scan burst broken or digit changed")

  // the latch word is the lowest select bit, set only for digit zero
  `SSD_ASSERT(a_latch_select, clk, rst, m_tvalid && m_tlast |-> (m_tdata[0] == (m_tdata[2:1] == 2'd0)), "wrong select bit on latch word")

  // scanned digit stays within the display
  `SSD_ASSERT(a_digit_range, clk, rst, m_tvalid |-> ({1'b0, m_tdata[2:1]} < 3'(SCAN_COUNT)), "digit index beyond scan range")

  // tick, show and clear keep the input busy for at least the next cycle
  `SSD_ASSERT(a_busy_after_word, clk, rst, s_tvalid && s_tready && (s_tuser != CMD_RAW) |=> !s_tready, "input ready straight after a multi-cycle word")

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (.*);

[tb/seven_segment_scan_driver_tb.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_tb
// self-checking bench for the four digit scan driver: a directed opening
// (blank display, saturation, leading zero blanking, points, raw writes,
// clear, full scan wrap), then some 180 random words with random gaps
// on both sides, one long receiver hold-off and one pause until the output
// side has drained; every serial bit is checked against a behavioural
// copy of the display store kept in a small scoreboard
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_tb;
  import ssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS  = 180;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int SCAN_LIMIT    = (DIGITS < 1) ? 1 : ((DIGITS > 4) ? 4 : DIGITS);

  // active-low glyphs for 0..9, bit 7 is the point
  localparam logic [7:0] GLYPH [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                        8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

  // one serial bit as it should leave the block
  typedef struct packed {
    logic       serial;
    logic [1:0] digit;
    logic       latch;
  } scan_bit_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the segment store and the scan pointer, expands
  // every accepted tick into its sixteen serial bits
  // --------------------------------------------------------------------------
  class display_scoreboard;
    logic [7:0] segments [4];
    logic [1:0] scan_pos;
    scan_bit_t  queued_bits [$];
    int         errors;

    function new();
      foreach (segments[i]) segments[i] = 8'hFF;
      scan_pos = 2'd0;
      errors   = 0;
    endfunction

    function int pending();
      return queued_bits.size();
    endfunction

    // accepted input word: update the store or queue the scan bits
    function void note_word(cmd_t cmd, logic [31:0] data);
      int         v;
      int         scale;
      logic [7:0] p;
      logic       lit;
      logic [15:0] frame;
      case (cmd)
        CMD_SHOW: begin
          // saturate before the decimal split
          v = (data[13:0] > 14'd9999) ? 9999 : int'(data[13:0]);
          scale = 1;
          for (int i = 0; i < 4; i++) begin
            lit = (i == 0) || data[14] || (v >= scale);
            if (lit) begin
              p = GLYPH[(v / scale) % 10];
              // point only lands on a lit digit
              if (data[16:15] != 2'd0 && data[16:15] == i) p = p & 8'h7F;
              segments[i] = p;
            end else begin
              segments[i] = 8'hFF;
            end
            scale = scale * 10;
          end
        end
        CMD_RAW: segments[data[26:25]] = data[24:17];
        CMD_CLEAR: foreach (segments[i]) segments[i] = 8'hFF;
        default: begin
          // tick: segment byte then one-hot select, msb first
          frame = {segments[scan_pos], 8'(1 << scan_pos)};
          for (int k = 0; k < 16; k++)
            queued_bits.push_back(scan_bit_t'{frame[15-k], scan_pos, (k == 15)});
          scan_pos = (int'(scan_pos) + 1 >= SCAN_LIMIT) ? 2'd0 : scan_pos + 2'd1;
        end
      endcase
    endfunction

    // accepted output word against the oldest queued bit
    function void check_bit(logic [7:0] tdata, logic tlast);
      scan_bit_t want;
      if (queued_bits.size() == 0) begin
        if (errors < 10)
          $display("unexpected output word: bit %0b digit %0d latch %0b",
                   tdata[0], tdata[2:1], tlast);
        errors++;
        return;
      end
      want = queued_bits.pop_front();
      if (tdata[0] !== want.serial || tdata[2:1] !== want.digit ||
          tlast !== want.latch) begin
        if (errors < 10)
          $display({"mismatch: expected bit %0b digit %0d latch %0b,",
                    " got bit %0b digit %0d latch %0b"},
                   want.serial, want.digit, want.latch, tdata[0], tdata[2:1], tlast);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // value[13:0], show_zero[14], dot_position[16:15], raw_pattern[24:17],
  // position[26:25], zero fill[31:27]
  logic [31:0] s_tdata  = '0;
  // command[1:0]
  logic [1:0]  s_tuser  = CMD_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // serial_bit[0], digit_index[2:1], zero fill[7:3]
  logic [7:0]  m_tdata;
  logic        m_tlast;

  // flags shared between the stimulus and the receiver process
  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;

  display_scoreboard sb = new();

  always #5 clk = ~clk;

  seven_segment_scan_driver i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pack_word(int value, bit show_zero, logic [1:0] dot,
                                            logic [7:0] raw, logic [1:0] pos);
    return {5'b0, pos, raw, dot, show_zero, value[13:0]};
  endfunction

  // offer one word, optionally after a random gap, and wait for the handshake
  task automatic send_word(input cmd_t cmd, input logic [31:0] data, input bit gaps = 1'b1);
    int g;
    g = gaps ? idle_len() : 0;
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop offering and wait until every queued bit has left the block
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic tick();
    send_word(CMD_TICK, pack_word(int'($urandom_range(0, 16383)),
                                  1'($urandom_range(0, 1)),
                                  2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3))));
  endtask

  // --------------------------------------------------------------------------
  // monitor: inputs are noted before outputs are checked in the same cycle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_word(cmd_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) sb.check_bit(m_tdata, m_tlast);
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random ready pattern, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int g;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      g = idle_len();
      if (g != 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int   r;
    int   v;
    cmd_t cmd;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // blank display straight after reset
    tick();
    // zero alone, leading zeros blanked
    send_word(CMD_SHOW, pack_word(0, 1'b0, 2'd0, 8'h00, 2'd0));
    tick();
    // largest value with a point on the top digit, then a full scan wrap
    send_word(CMD_SHOW, pack_word(9999, 1'b0, 2'd3, 8'hFF, 2'd3));
    repeat (4) tick();
    // over-range value saturates, leading zeros shown, point on digit one
    send_word(CMD_SHOW, pack_word(16383, 1'b1, 2'd1, 8'h00, 2'd0));
    tick();
    // point requested on a blanked digit stays off
    send_word(CMD_SHOW, pack_word(7, 1'b0, 2'd2, 8'hFF, 2'd3));
    repeat (2) tick();
    // short number with zeros shown, then raw writes over it
    send_word(CMD_SHOW, pack_word(42, 1'b1, 2'd0, 8'h00, 2'd0));
    send_word(CMD_RAW, pack_word(0, 1'b0, 2'd0, 8'h00, 2'd0));
    send_word(CMD_RAW, pack_word(16383, 1'b1, 2'd3, 8'hFF, 2'd1));
    send_word(CMD_RAW, pack_word(0, 1'b0, 2'd0, 8'hAA, 2'd2));
    send_word(CMD_RAW, pack_word(0, 1'b0, 2'd0, 8'h55, 2'd3));
    repeat (4) tick();
    // clear blanks everything again
    send_word(CMD_CLEAR, pack_word(9999, 1'b1, 2'd3, 8'h00, 2'd3));
    repeat (4) tick();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // long receiver hold-off while ticks keep coming, fills the block
      if (n == 40) begin
        hold_req = 1'b1;
        repeat (12) send_word(CMD_TICK, pack_word(0, 1'b0, 2'd0, 8'h00, 2'd0), 1'b0);
      end
      // sender pause until the output side has caught up
      if (n == 120) drain();
      no_idle = (n >= 150 && n < 170);

      r = $urandom_range(0, 99);
      cmd = (r < 45) ? CMD_TICK : (r < 75) ? CMD_SHOW : (r < 90) ? CMD_RAW : CMD_CLEAR;
      // spread the values over every digit count, a few beyond the range
      r = $urandom_range(0, 99);
      if (r < 25)      v = $urandom_range(0, 9);
      else if (r < 45) v = $urandom_range(10, 99);
      else if (r < 60) v = $urandom_range(100, 999);
      else if (r < 85) v = $urandom_range(1000, 9999);
      else             v = $urandom_range(0, 16383);
      send_word(cmd, pack_word(v, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               8'($urandom_range(0, 255)), 2'($urandom_range(0, 3))));
    end
    no_idle = 1'b0;

    drain();
    // let any stray output word show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
